>>> hdl/pwmdm_pkg.sv
package pwmdm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CaptureBitsDef  = 14;
  localparam int unsigned OverflowBitsDef = 8;

  // Fixed field widths.
  localparam int unsigned PeriodW  = 23;
  localparam int unsigned DutyW    = 10;
  localparam int unsigned SecW     = 32;
  localparam int unsigned TosW     = 16;
  localparam int unsigned ErrW     = 10;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned CfgIdxW  = 3;

  // Register reset values.
  localparam logic [PeriodW-1:0] MinPeriodRst   = 23'd2500;
  localparam logic [PeriodW-1:0] MaxPeriodRst   = 23'd125000;
  localparam logic               TimeoutEnRst   = 1'b1;
  localparam logic [TosW-1:0]    TimeoutSecRst  = 16'd2;
  localparam logic [ErrW-1:0]    ConfirmErrRst  = 10'd10;
  localparam logic [TicksW-1:0]  ConfirmTickRst = 16'd10;

  // Counts run at 1.5 MHz, so microseconds are count * 2 / 3.
  localparam logic [1:0] Div3Divisor = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_PERIOD   = 3'd0,
    REG_MAX_PERIOD   = 3'd1,
    REG_TIMEOUT_EN   = 3'd2,
    REG_TIMEOUT_SEC  = 3'd3,
    REG_CONFIRM_ERR  = 3'd4,
    REG_CONFIRM_TICK = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_RISE = 2'd0,
    KIND_FALL = 2'd1,
    KIND_OVF  = 2'd2,
    KIND_TICK = 2'd3
  } kind_e;

endpackage

>>> hdl/pwm_input_duty_measure_confirm.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  kind_i, capture_count_i, now_seconds_i
// result    out        out_valid_o/out_stall_i duty_permille_o, confirmed_duty_o,
//                                             period_us_o, offline_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// The block works on one request at a time, and each request gives exactly one result.
// A rising edge passes the divide by three, the period sum, the range check and the duty
// divider, which is skipped when the period is rejected; a falling edge only the divide
// by three; a tick the timeout check (unless it is off) and the filter; an overflow none.
// The divide by three takes one count bit per cycle and the duty divider one quotient bit.
// Reset clears all state and loads the register defaults. A stalled result holds in the
// output register while the next request is already accepted.
module pwm_input_duty_measure_confirm #(
  parameter int unsigned CAPTURE_BITS  = pwmdm_pkg::CaptureBitsDef,
  parameter int unsigned OVERFLOW_BITS = pwmdm_pkg::OverflowBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     kind_i,
  input  logic [CAPTURE_BITS-1:0]        capture_count_i,
  input  logic [pwmdm_pkg::SecW-1:0]     now_seconds_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pwmdm_pkg::DutyW-1:0]    duty_permille_o,
  output logic [pwmdm_pkg::DutyW-1:0]    confirmed_duty_o,
  output logic [pwmdm_pkg::PeriodW-1:0]  period_us_o,
  output logic                           offline_o,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [pwmdm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwmdm_pkg::CfgDataW-1:0] cfg_data_i
);

  // Raw count with overflows folded in, and the time derived from it.
  localparam int unsigned CntW  = CAPTURE_BITS + OVERFLOW_BITS;
  // Period is the sum of two times.
  localparam int unsigned PerW  = CntW + 1;
  // Width in which the period is compared against the 23-bit bounds.
  localparam int unsigned CmpW  = (PerW > pwmdm_pkg::PeriodW) ? PerW : pwmdm_pkg::PeriodW;
  // The dividend of the divide by three is count * 2.
  localparam int unsigned D3W   = CntW + 1;
  // Duty numerator high * 1000 and the divisor period << (DutyW - 1).
  localparam int unsigned DivW  = PerW + pwmdm_pkg::DutyW - 1;
  localparam int unsigned StepW = $clog2(D3W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV3,
    S_PERIOD,
    S_RANGE,
    S_DUTY,
    S_TIMEOUT,
    S_CONFIRM,
    S_DONE
  } state_e;

  // Configuration registers.
  logic [pwmdm_pkg::PeriodW-1:0] min_period_q;
  logic [pwmdm_pkg::PeriodW-1:0] max_period_q;
  logic                          timeout_en_q;
  logic [pwmdm_pkg::TosW-1:0]    timeout_sec_q;
  logic [pwmdm_pkg::ErrW-1:0]    confirm_err_q;
  logic [pwmdm_pkg::TicksW-1:0]  confirm_ticks_q;

  // Measurement and filter state.
  state_e                        state_q;
  pwmdm_pkg::kind_e              kind_q;
  logic [pwmdm_pkg::SecW-1:0]    now_q;
  logic [OVERFLOW_BITS-1:0]      ovf_q;
  logic [CntW-1:0]               high_q;
  logic [PerW-1:0]               period_q;
  logic [pwmdm_pkg::DutyW-1:0]   duty_q;
  logic [pwmdm_pkg::SecW-1:0]    last_edge_q;
  logic                          offline_q;
  logic [pwmdm_pkg::DutyW-1:0]   cand_q;
  logic [pwmdm_pkg::TicksW-1:0]  stable_q;
  logic [pwmdm_pkg::DutyW-1:0]   accepted_q;

  // Serial datapath.
  logic [StepW-1:0]              step_q;
  logic [D3W-1:0]                sh_q;
  logic [1:0]                    rem3_q;
  logic [DivW-1:0]               rem_q;
  logic [DivW-1:0]               dvs_q;
  logic [pwmdm_pkg::DutyW-1:0]   quot_q;

  // Output register.
  logic                          out_valid_q;
  logic [pwmdm_pkg::DutyW-1:0]   out_duty_q;
  logic [pwmdm_pkg::DutyW-1:0]   out_conf_q;
  logic [pwmdm_pkg::PeriodW-1:0] out_period_q;
  logic                          out_offline_q;

  logic                          in_accept;
  logic                          out_free;
  logic [CntW-1:0]               edge_cnt;
  logic [2:0]                    r3;
  logic                          q3;
  logic [1:0]                    r3_next;
  logic [PerW-1:0]               period_sum;
  logic [CmpW-1:0]               period_ext;
  logic [CmpW-1:0]               min_ext;
  logic [CmpW-1:0]               max_ext;
  logic                          period_ok;
  logic [DivW-1:0]               numerator;
  logic                          div_ge;
  logic [pwmdm_pkg::SecW:0]      age;
  logic                          expired;
  logic [pwmdm_pkg::DutyW-1:0]   duty_diff;
  logic [pwmdm_pkg::TicksW:0]    stable_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Pending overflows each stand for one full counter span.
  assign edge_cnt = CntW'(capture_count_i)
                  + (CntW'(ovf_q) << CAPTURE_BITS) - CntW'(ovf_q);

  // One bit of the divide by three: the remainder stays below three.
  assign r3      = {rem3_q, sh_q[D3W-1]};
  assign q3      = (r3 >= {1'b0, pwmdm_pkg::Div3Divisor});
  assign r3_next = q3 ? 2'(r3 - {1'b0, pwmdm_pkg::Div3Divisor}) : r3[1:0];

  assign period_sum = PerW'(high_q) + PerW'(sh_q[CntW-1:0]);
  assign period_ext = CmpW'(period_q);
  assign min_ext    = CmpW'(min_period_q);
  assign max_ext    = CmpW'(max_period_q);
  assign period_ok  = (period_ext >= min_ext) && (period_ext <= max_ext)
                   && (period_q != '0);

  // high * 1000 as high * (1024 - 16 - 8).
  assign numerator = (DivW'(high_q) << 10) - (DivW'(high_q) << 4) - (DivW'(high_q) << 3);
  assign div_ge    = (rem_q >= dvs_q);

  // A borrow means the clock went backwards, which also counts as expired.
  assign age     = {1'b0, now_q} - {1'b0, last_edge_q};
  assign expired = age[pwmdm_pkg::SecW]
                || (age[pwmdm_pkg::SecW-1:0] > pwmdm_pkg::SecW'(timeout_sec_q));

  assign duty_diff  = (duty_q > cand_q) ? (duty_q - cand_q) : (cand_q - duty_q);
  assign stable_inc = {1'b0, stable_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period_q    <= pwmdm_pkg::MinPeriodRst;
      max_period_q    <= pwmdm_pkg::MaxPeriodRst;
      timeout_en_q    <= pwmdm_pkg::TimeoutEnRst;
      timeout_sec_q   <= pwmdm_pkg::TimeoutSecRst;
      confirm_err_q   <= pwmdm_pkg::ConfirmErrRst;
      confirm_ticks_q <= pwmdm_pkg::ConfirmTickRst;
    end else if (cfg_we_i) begin
      unique case (pwmdm_pkg::cfg_idx_e'(cfg_idx_i))
        pwmdm_pkg::REG_MIN_PERIOD:   min_period_q    <= cfg_data_i;
        pwmdm_pkg::REG_MAX_PERIOD:   max_period_q    <= cfg_data_i;
        pwmdm_pkg::REG_TIMEOUT_EN:   timeout_en_q    <= cfg_data_i[0];
        pwmdm_pkg::REG_TIMEOUT_SEC:  timeout_sec_q   <= cfg_data_i[pwmdm_pkg::TosW-1:0];
        pwmdm_pkg::REG_CONFIRM_ERR:  confirm_err_q   <= cfg_data_i[pwmdm_pkg::ErrW-1:0];
        pwmdm_pkg::REG_CONFIRM_TICK: confirm_ticks_q <= cfg_data_i[pwmdm_pkg::TicksW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the measurement state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kind_q        <= pwmdm_pkg::KIND_RISE;
      now_q         <= '0;
      ovf_q         <= '0;
      high_q        <= '0;
      period_q      <= '0;
      duty_q        <= '0;
      last_edge_q   <= '0;
      offline_q     <= 1'b0;
      cand_q        <= '0;
      stable_q      <= '0;
      accepted_q    <= '0;
      step_q        <= '0;
      sh_q          <= '0;
      rem3_q        <= '0;
      rem_q         <= '0;
      dvs_q         <= '0;
      quot_q        <= '0;
      out_valid_q   <= 1'b0;
      out_duty_q    <= '0;
      out_conf_q    <= '0;
      out_period_q  <= '0;
      out_offline_q <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one is loaded now.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            kind_q <= pwmdm_pkg::kind_e'(kind_i);
            now_q  <= now_seconds_i;
            unique case (pwmdm_pkg::kind_e'(kind_i))
              pwmdm_pkg::KIND_RISE, pwmdm_pkg::KIND_FALL: begin
                sh_q    <= {edge_cnt, 1'b0};
                rem3_q  <= '0;
                step_q  <= '0;
                ovf_q   <= '0;
                state_q <= S_DIV3;
              end
              pwmdm_pkg::KIND_OVF: begin
                if (ovf_q != '1) begin
                  ovf_q <= ovf_q + 1'b1;
                end
                state_q <= S_DONE;
              end
              pwmdm_pkg::KIND_TICK: begin
                state_q <= timeout_en_q ? S_TIMEOUT : S_CONFIRM;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_DIV3: begin
          // Dividend bits leave at the top while quotient bits enter below.
          sh_q   <= {sh_q[D3W-2:0], q3};
          rem3_q <= r3_next;
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(D3W - 1)) begin
            state_q <= S_PERIOD;
          end
        end
        S_PERIOD: begin
          if (kind_q == pwmdm_pkg::KIND_FALL) begin
            high_q  <= sh_q[CntW-1:0];
            state_q <= S_DONE;
          end else begin
            period_q <= period_sum;
            state_q  <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (period_ok) begin
            last_edge_q <= now_q;
            rem_q       <= numerator;
            dvs_q       <= DivW'(period_q) << (pwmdm_pkg::DutyW - 1);
            quot_q      <= '0;
            step_q      <= '0;
            state_q     <= S_DUTY;
          end else begin
            duty_q  <= '0;
            state_q <= S_DONE;
          end
        end
        S_DUTY: begin
          // Restoring division; high never exceeds the period, so ten bits suffice.
          if (div_ge) begin
            rem_q <= rem_q - dvs_q;
          end
          dvs_q  <= dvs_q >> 1;
          quot_q <= {quot_q[pwmdm_pkg::DutyW-2:0], div_ge};
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(pwmdm_pkg::DutyW - 1)) begin
            duty_q  <= {quot_q[pwmdm_pkg::DutyW-2:0], div_ge};
            state_q <= S_DONE;
          end
        end
        S_TIMEOUT: begin
          if (expired) begin
            duty_q      <= '0;
            high_q      <= '0;
            period_q    <= '0;
            ovf_q       <= '0;
            last_edge_q <= '0;
            offline_q   <= 1'b1;
          end else begin
            offline_q <= 1'b0;
          end
          state_q <= S_CONFIRM;
        end
        S_CONFIRM: begin
          if (duty_diff > confirm_err_q) begin
            stable_q <= '0;
            cand_q   <= duty_q;
          end else if (stable_inc >= {1'b0, confirm_ticks_q}) begin
            accepted_q <= cand_q;
            stable_q   <= '0;
          end else begin
            stable_q <= stable_inc[pwmdm_pkg::TicksW-1:0];
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_duty_q    <= duty_q;
            out_conf_q    <= accepted_q;
            out_period_q  <= period_ext[pwmdm_pkg::PeriodW-1:0];
            out_offline_q <= offline_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_permille_o  = out_duty_q;
  assign confirmed_duty_o = out_conf_q;
  assign period_us_o      = out_period_q;
  assign offline_o        = out_offline_q;

  // An accepted request always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request accepted but block not busy");

  // A new result appears only after the sequencer finished a request.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == S_DONE))
    else $error("result shown without a finished request");

  // The confirmed duty only moves in the confirmation step.
  a_accept_in_confirm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(accepted_q) |-> $past(state_q == S_CONFIRM))
    else $error("confirmed duty changed outside the filter step");

  // Measured duty never exceeds one thousand permille.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_permille_o <= 10'd1000) && (confirmed_duty_o <= 10'd1000))
    else $error("duty out of range");

endmodule

>>> tb/pwm_input_duty_measure_confirm_tb.sv
module pwm_input_duty_measure_confirm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwmdm_pkg::*;

  // The capture counter wraps at this span, so each pending overflow is worth it.
  localparam longint unsigned CaptureSpan = (64'd1 << CaptureBitsDef) - 64'd1;
  // Watchdog limit for the whole run.
  localparam int CycleLimit = 1000000;
  // Longest request in the block (rising edge) plus some slack.
  localparam int DrainCycles = 60;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One result of the block, held with the widths of its ports.
  typedef struct packed {
    logic [DutyW-1:0]   duty;
    logic [DutyW-1:0]   confirmed;
    logic [PeriodW-1:0] period;
    logic               offline;
  } pwm_reading_t;

  logic                      clk_i;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                kind_i          = KIND_TICK;
  logic [CaptureBitsDef-1:0] capture_count_i = '0;
  logic [SecW-1:0]           now_seconds_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [DutyW-1:0]          duty_permille_o;
  logic [DutyW-1:0]          confirmed_duty_o;
  logic [PeriodW-1:0]        period_us_o;
  logic                      offline_o;
  logic                      cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i       = REG_MIN_PERIOD;
  logic [CfgDataW-1:0]       cfg_data_i      = '0;

  pwm_input_duty_measure_confirm u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .kind_i           (kind_i),
    .capture_count_i  (capture_count_i),
    .now_seconds_i    (now_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .duty_permille_o  (duty_permille_o),
    .confirmed_duty_o (confirmed_duty_o),
    .period_us_o      (period_us_o),
    .offline_o        (offline_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Register copies as the block should hold them.
  logic [PeriodW-1:0] min_period_cfg;
  logic [PeriodW-1:0] max_period_cfg;
  logic               timeout_en_cfg;
  logic [TosW-1:0]    timeout_sec_cfg;
  logic [ErrW-1:0]    confirm_err_cfg;
  logic [TicksW-1:0]  confirm_ticks_cfg;

  // Measurement and filter state as the block should hold it.
  logic [OverflowBitsDef-1:0] ovf_pending;
  logic [21:0]                high_us;
  logic [21:0]                low_us;
  logic [PeriodW-1:0]         period_now;
  logic [DutyW-1:0]           duty_now;
  logic [SecW-1:0]            edge_second;
  logic                       offline_now;
  logic [DutyW-1:0]           candidate;
  logic [TicksW-1:0]          stable_ticks;
  logic [DutyW-1:0]           accepted;

  pwm_reading_t expected_readings[$];
  pwm_reading_t want;

  idle_mode_e idle_mode      = IDLE_NONE;
  int         gap_pct        = 0;
  int         stall_pct      = 0;
  int         cycle_count    = 0;
  int         mismatches     = 0;
  int         requests_sent  = 0;
  int         readings_seen  = 0;
  int         settings_run   = 0;
  logic [SecW-1:0] wall_sec  = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               expected_readings.size());
      $display("pwm_input_duty_measure_confirm_tb NOT OK");
      $finish;
    end
  end

  // The receiver stalls at random, at the rate of the current idle mode.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic flag_mismatch(string what, longint unsigned want_v, longint unsigned got_v);
    mismatches++;
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what,
             want_v, got_v);
  endtask

  // Every accepted result is checked against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_readings.size() == 0) begin
        flag_mismatch("result with no request outstanding, duty", 0, duty_permille_o);
      end else begin
        want = expected_readings.pop_front();
        readings_seen++;
        if (duty_permille_o !== want.duty) begin
          flag_mismatch("duty_permille", want.duty, duty_permille_o);
        end
        if (confirmed_duty_o !== want.confirmed) begin
          flag_mismatch("confirmed_duty", want.confirmed, confirmed_duty_o);
        end
        if (period_us_o !== want.period) begin
          flag_mismatch("period_us", want.period, period_us_o);
        end
        if (offline_o !== want.offline) begin
          flag_mismatch("offline", want.offline, offline_o);
        end
      end
    end
  end

  // Turns a captured count plus the pending overflows into microseconds.
  // The counter runs at 1.5 MHz, hence the factor two thirds.
  function automatic logic [21:0] level_time_us(logic [CaptureBitsDef-1:0] raw);
    longint unsigned ticks;
    ticks = longint'(raw) + longint'(ovf_pending) * CaptureSpan;
    ovf_pending = '0;
    return 22'((ticks * 2) / 3);
  endfunction

  // Advances the state by one accepted request and queues the result it must give.
  function automatic void predict_reading(kind_e kind, logic [CaptureBitsDef-1:0] raw,
                                          logic [SecW-1:0] now);
    logic [DutyW-1:0] drift;
    logic [TicksW:0]  next_stable;
    pwm_reading_t     r;
    case (kind)
      KIND_RISE: begin
        low_us = level_time_us(raw);
        period_now = PeriodW'(high_us) + PeriodW'(low_us);
        // A zero period is never a measurement, whatever the lower bound says.
        if (period_now >= min_period_cfg && period_now <= max_period_cfg &&
            period_now != 0) begin
          duty_now = DutyW'((longint'(high_us) * 1000) / longint'(period_now));
          edge_second = now;
        end else begin
          duty_now = '0;
        end
      end
      KIND_FALL: begin
        high_us = level_time_us(raw);
      end
      KIND_OVF: begin
        if (!(&ovf_pending)) ovf_pending++;
      end
      default: begin
        if (timeout_en_cfg) begin
          // A clock that went backwards counts as a timeout too.
          if ((now > edge_second && (now - edge_second) > SecW'(timeout_sec_cfg)) ||
              now < edge_second) begin
            duty_now    = '0;
            high_us     = '0;
            low_us      = '0;
            period_now  = '0;
            ovf_pending = '0;
            edge_second = '0;
            offline_now = 1'b1;
          end else begin
            offline_now = 1'b0;
          end
        end
        drift = (duty_now > candidate) ? duty_now - candidate : candidate - duty_now;
        if (drift > confirm_err_cfg) begin
          stable_ticks = '0;
          candidate    = duty_now;
        end else begin
          next_stable = stable_ticks + 1'b1;
          if (next_stable >= confirm_ticks_cfg) begin
            accepted     = candidate;
            stable_ticks = '0;
          end else begin
            stable_ticks = next_stable[TicksW-1:0];
          end
        end
      end
    endcase
    r.duty      = duty_now;
    r.confirmed = accepted;
    r.period    = period_now;
    r.offline   = offline_now;
    expected_readings.push_back(r);
  endfunction

  // Sends one request. The sender may first sit idle; the request then holds until
  // the block takes it, and stays driven so that a following request can reuse it.
  task automatic send_event(kind_e kind, logic [CaptureBitsDef-1:0] raw,
                            logic [SecW-1:0] now);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    capture_count_i <= raw;
    now_seconds_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    predict_reading(kind, raw, now);
    requests_sent++;
  endtask

  // Lets every outstanding result come back, so the block is idle afterwards.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_MIN_PERIOD:   min_period_cfg    = value;
      REG_MAX_PERIOD:   max_period_cfg    = value;
      REG_TIMEOUT_EN:   timeout_en_cfg    = value[0];
      REG_TIMEOUT_SEC:  timeout_sec_cfg   = value[TosW-1:0];
      REG_CONFIRM_ERR:  confirm_err_cfg   = value[ErrW-1:0];
      REG_CONFIRM_TICK: confirm_ticks_cfg = value[TicksW-1:0];
      default: ;
    endcase
  endtask

  // Waits for the block to go idle, then loads a full register setting and
  // picks how both sides of the handshakes idle during the next stretch.
  task automatic program_setting(int min_p, int max_p, int ten, int tsec, int err,
                                 int ticks, idle_mode_e mode);
    drain_results();
    write_reg(REG_MIN_PERIOD, CfgDataW'(min_p));
    write_reg(REG_MAX_PERIOD, CfgDataW'(max_p));
    write_reg(REG_TIMEOUT_EN, CfgDataW'(ten));
    write_reg(REG_TIMEOUT_SEC, CfgDataW'(tsec));
    write_reg(REG_CONFIRM_ERR, CfgDataW'(err));
    write_reg(REG_CONFIRM_TICK, CfgDataW'(ticks));
    cfg_we_i  <= 1'b0;
    idle_mode = mode;
    gap_pct   = (idle_mode == IDLE_SENDER) ? 56 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 56 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    settings_run++;
  endtask

  // A level count for a new waveform: mostly anywhere, sometimes very short
  // (periods below the window, zero included) or near the counter maximum.
  function automatic logic [CaptureBitsDef-1:0] pick_level_count();
    case ($urandom_range(5))
      0:       return CaptureBitsDef'($urandom_range(40));
      1:       return CaptureBitsDef'(CaptureSpan - $urandom_range(40));
      default: return CaptureBitsDef'($urandom);
    endcase
  endfunction

  // Small jitter around a level so that the confirmation filter sees a steady duty.
  function automatic logic [CaptureBitsDef-1:0] wobble(logic [CaptureBitsDef-1:0] c);
    int v;
    v = int'(c) + $urandom_range(16) - 8;
    if (v < 0) v = 0;
    if (v > int'(CaptureSpan)) v = int'(CaptureSpan);
    return CaptureBitsDef'(v);
  endfunction

  // Mostly well-formed PWM traffic: optional overflows, the falling edge with the
  // high count, the rising edge with the low count, then a few ticks. The waveform
  // stays put for a while so that duties get confirmed; now and then the seconds
  // jump ahead or back to trip the timeout. About one round in ten sends noise instead.
  task automatic run_pwm_traffic(int n);
    int                        stop_at;
    int                        roll;
    logic [CaptureBitsDef-1:0] hi_cnt;
    logic [CaptureBitsDef-1:0] lo_cnt;
    stop_at  = requests_sent + n;
    hi_cnt   = pick_level_count();
    lo_cnt   = pick_level_count();
    wall_sec = $urandom;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        send_event(kind_e'($urandom_range(3)), CaptureBitsDef'($urandom),
                   (roll < 5) ? SecW'($urandom) : wall_sec + $urandom_range(4));
      end else begin
        if ($urandom_range(7) == 0) begin
          hi_cnt = pick_level_count();
          lo_cnt = pick_level_count();
        end
        hi_cnt = wobble(hi_cnt);
        lo_cnt = wobble(lo_cnt);
        repeat (($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0) begin
          send_event(KIND_OVF, CaptureBitsDef'($urandom), wall_sec);
        end
        send_event(KIND_FALL, hi_cnt, wall_sec);
        if ($urandom_range(9) == 0) send_event(KIND_OVF, CaptureBitsDef'($urandom), wall_sec);
        send_event(KIND_RISE, lo_cnt, wall_sec);
        repeat ($urandom_range(3)) begin
          if ($urandom_range(3) == 0) wall_sec++;
          if ($urandom_range(31) == 0) begin
            wall_sec = $urandom_range(1) ? wall_sec + $urandom_range(3, 70000)
                                         : wall_sec - $urandom_range(1, 1000);
          end
          send_event(KIND_TICK, CaptureBitsDef'($urandom), wall_sec);
        end
      end
    end
  endtask

  // Reset settings: count extremes, a zero period, a too short period and an
  // edge that carries pending overflows.
  task automatic test_edge_extremes();
    send_event(KIND_TICK, '0, 32'd0);
    send_event(KIND_FALL, CaptureBitsDef'(CaptureSpan), 32'd5);
    send_event(KIND_RISE, '0, 32'd5);
    send_event(KIND_FALL, '0, 32'd5);
    send_event(KIND_RISE, CaptureBitsDef'(CaptureSpan), 32'd5);
    send_event(KIND_FALL, '0, 32'd5);
    send_event(KIND_RISE, '0, 32'd5);
    send_event(KIND_FALL, 14'd1500, 32'd5);
    send_event(KIND_RISE, 14'd1500, 32'd5);
    repeat (3) send_event(KIND_OVF, 14'd0, 32'd5);
    send_event(KIND_FALL, 14'd100, 32'd5);
    send_event(KIND_RISE, 14'd3000, 32'd5);
    send_event(KIND_OVF, CaptureBitsDef'(CaptureSpan), 32'd5);
    send_event(KIND_RISE, CaptureBitsDef'(CaptureSpan), 32'd5);
  endtask

  // Timeout edges: exactly at the limit, one past it, a clock that runs
  // backwards, and the top of the seconds range.
  task automatic test_edge_timeout();
    send_event(KIND_TICK, '0, 32'd7);
    send_event(KIND_TICK, '0, 32'd8);
    send_event(KIND_TICK, '0, 32'd2);
    send_event(KIND_FALL, 14'd8000, 32'd100);
    send_event(KIND_RISE, 14'd8000, 32'd100);
    send_event(KIND_TICK, CaptureBitsDef'(CaptureSpan), 32'd50);
    send_event(KIND_FALL, 14'd8000, 32'hFFFF_FFFF);
    send_event(KIND_RISE, 14'd8000, 32'hFFFF_FFFF);
    send_event(KIND_TICK, '0, 32'hFFFF_FFFF);
    send_event(KIND_TICK, '0, 32'd0);
  endtask

  // Widest window, strict timeout and a filter that confirms every stable tick.
  task automatic test_wide_window();
    program_setting(1, 5592405, 1, 0, 0, 1, IDLE_SENDER);
    run_pwm_traffic(150);
  endtask

  // The overflow count must stop at its maximum; the wide window then accepts the
  // long period that results.
  task automatic test_overflow_saturation();
    wall_sec = $urandom;
    repeat (258) send_event(KIND_OVF, CaptureBitsDef'($urandom), wall_sec);
    send_event(KIND_FALL, CaptureBitsDef'(CaptureSpan), wall_sec);
    send_event(KIND_OVF, '0, wall_sec);
    send_event(KIND_RISE, CaptureBitsDef'(CaptureSpan), wall_sec);
    send_event(KIND_TICK, '0, wall_sec);
  endtask

  // Bounds swapped, so no period passes; timeout off, the loosest filter.
  task automatic test_inverted_window();
    program_setting(5592405, 1, 0, 65535, 1000, 65535, IDLE_RECEIVER);
    run_pwm_traffic(150);
  endtask

  task automatic test_nominal_window();
    program_setting(2500, 125000, 1, 3, 10, 3, IDLE_BOTH);
    run_pwm_traffic(150);
  endtask

  // A zero lower bound still refuses a zero period; zero confirm ticks confirm at once.
  task automatic test_zero_bounds();
    program_setting(0, 20000, 1, 65535, 5, 0, IDLE_NONE);
    run_pwm_traffic(150);
  endtask

  // Timeout off, so offline keeps whatever it was; error wider than any duty step.
  task automatic test_timeout_disabled();
    program_setting(1000, 30000, 0, 5, 1023, 2, IDLE_RECEIVER);
    run_pwm_traffic(140);
  endtask

  task automatic test_relaxed_filter();
    program_setting(2500, 125000, 1, 10, 20, 5, IDLE_BOTH);
    run_pwm_traffic(140);
  endtask

  initial begin
    // Predictor state mirrors the reset values of the block.
    min_period_cfg    = MinPeriodRst;
    max_period_cfg    = MaxPeriodRst;
    timeout_en_cfg    = TimeoutEnRst;
    timeout_sec_cfg   = TimeoutSecRst;
    confirm_err_cfg   = ConfirmErrRst;
    confirm_ticks_cfg = ConfirmTickRst;
    ovf_pending       = '0;
    high_us           = '0;
    low_us            = '0;
    period_now        = '0;
    duty_now          = '0;
    edge_second       = '0;
    offline_now       = 1'b0;
    candidate         = '0;
    stable_ticks      = '0;
    accepted          = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_extremes();
    test_edge_timeout();
    test_wide_window();
    test_overflow_saturation();
    test_inverted_window();
    test_nominal_window();
    test_zero_bounds();
    test_timeout_disabled();
    test_relaxed_filter();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests sent and %0d results checked over %0d register settings",
             requests_sent, readings_seen, settings_run);
    $display("covered edges, overflows with saturation, ticks, timeouts and the filter");
    if (mismatches == 0) begin
      $display("pwm_input_duty_measure_confirm_tb OK");
    end else begin
      $display("pwm_input_duty_measure_confirm_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/pwmdm_pkg.sv
hdl/pwm_input_duty_measure_confirm.sv
tb/pwm_input_duty_measure_confirm_tb.sv
